FILE: rtl/ttcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traction torque command shaper package
// Field widths, register indexes, inverter state codes and serial unit
// step counts shared by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package ttcs_pkg;

   localparam int PEDAL_W  = 7;
   localparam int STATE_W  = 2;
   localparam int SPEED_W  = 16;
   localparam int POWER_W  = 20;
   localparam int TORQUE_W = 16;
   localparam int LIMIT_W  = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Serial multiply / divide unit
   localparam int MCAND_W   = 32;
   localparam int PROD_W    = MCAND_W + POWER_W;
   localparam int DIVD_W    = PROD_W - 16;
   localparam int DIVR_W    = 16;
   localparam int MUL_STEPS = POWER_W;
   localparam int DIV_STEPS = DIVD_W;
   localparam int CNT_W     = 6;

   localparam logic [PEDAL_W-1:0] PEDAL_DEAD   = 7'd10;
   localparam logic [DIVR_W-1:0]  PERCENT_DIV  = 16'd100;
   localparam logic [DIVR_W-1:0]  SPEED_FLOOR  = 16'd10;
   localparam logic [LIMIT_W-1:0] RAW_SAT      = 15'h7FFF;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_MODE         = 3'd0;
   localparam csr_index_type REG_SETPOINT_MAX = 3'd1;
   localparam csr_index_type REG_RATE_STEP    = 3'd2;
   localparam csr_index_type REG_LIMIT_POS    = 3'd3;
   localparam csr_index_type REG_LIMIT_NEG    = 3'd4;
   localparam csr_index_type REG_MAX_SPEED    = 3'd5;
   localparam csr_index_type REG_POWER_GAIN   = 3'd6;
   localparam csr_index_type REG_TORQUE_CAP   = 3'd7;

   typedef logic [STATE_W-1:0] inv_state_type;
   localparam inv_state_type INV_OFF     = 2'd0;
   localparam inv_state_type INV_ERROR   = 2'd1;
   localparam inv_state_type INV_READY   = 2'd2;
   localparam inv_state_type INV_RUNNING = 2'd3;

endpackage

FILE: rtl/ttcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traction torque command shaper channels
// Valid/ready interfaces for the request, response and register write
// channels of the shaper.
// ----------------------------------------------------------------------------
interface ttcs_req_if;
   logic                               valid;
   logic                               ready;
   logic [ttcs_pkg::PEDAL_W-1:0]       pedal;
   logic                               allowed;
   logic [ttcs_pkg::STATE_W-1:0]       inverter_state;
   logic signed [ttcs_pkg::SPEED_W-1:0] speed;
   logic [ttcs_pkg::POWER_W-1:0]       power;

   modport source (output valid, pedal, allowed, inverter_state, speed, power,
                   input ready);
   modport sink   (input valid, pedal, allowed, inverter_state, speed, power,
                   output ready);
endinterface

interface ttcs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ttcs_pkg::TORQUE_W-1:0] torque_command;
   logic [ttcs_pkg::LIMIT_W-1:0]         pos_limit_out;
   logic signed [ttcs_pkg::TORQUE_W-1:0] neg_limit_out;
   logic [ttcs_pkg::LIMIT_W-1:0]         dynamic_limit;

   modport source (output valid, torque_command, pos_limit_out, neg_limit_out,
                   dynamic_limit, input ready);
   modport sink   (input valid, torque_command, pos_limit_out, neg_limit_out,
                   dynamic_limit, output ready);
endinterface

interface ttcs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ttcs_pkg::CSR_IDX_W-1:0]    index;
   logic [ttcs_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/traction_torque_command_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traction torque command shaper
// Turns pedal position into a rate-limited, clamped torque setpoint with
// a power over speed dynamic torque limit, once per control tick.
//
// Channels: req_chan takes one request per tick (pedal, allowed, inverter
// state, speed, power); rsp_chan returns at most one response (torque
// command, limit words, dynamic limit); csr_chan writes the eight
// registers, always ready; write them only while no request is in flight.
// Flow: a request in off or error state gives no response and the
// block stays ready. A request that is not allowed goes straight to the
// shaping state, which registers its response. Otherwise one shared
// bit-serial unit runs twice, 20 multiply and 36 divide steps per pass
// (pedal scaling by 100, then power over speed), then the rate state;
// the shaping state then registers the response and returns to idle.
// One request is in flight at a time; req_chan.ready is low while busy.
// Reset clears the eight registers, the previous setpoint and the response.
// A stalled response holds in its register; the next request may be
// accepted meanwhile and its result waits until the old one is taken.
// ----------------------------------------------------------------------------
module traction_torque_command_shaper (
   input  logic        clock,
   input  logic        reset,
   ttcs_req_if.sink    req_chan,
   ttcs_rsp_if.source  rsp_chan,
   ttcs_csr_if.sink    csr_chan
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_RATE  = 3'd3;
   localparam logic [2:0] ST_SHAPE = 3'd4;

   localparam int PW = ttcs_pkg::PROD_W;
   localparam int MW = ttcs_pkg::MCAND_W;
   localparam int NW = ttcs_pkg::POWER_W;
   localparam int DW = ttcs_pkg::DIVR_W;
   localparam int LW = ttcs_pkg::LIMIT_W;
   localparam int TW = ttcs_pkg::TORQUE_W;
   localparam int CW = ttcs_pkg::CNT_W;
   localparam int SPW = ttcs_pkg::SPEED_W;

   // registers
   logic [1:0]           mode_ff;
   logic [LW-1:0]        setpoint_max_ff, rate_step_ff, limit_pos_ff;
   logic signed [TW-1:0] limit_neg_ff;
   logic [LW-1:0]        max_speed_ff, torque_cap_ff;
   logic [MW-1:0]        power_gain_ff;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pass_ff, pass_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [MW-1:0]        mcand_ff, mcand_in;
   logic [DW-1:0]        divr_ff, divr_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [LW-1:0]        quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic [LW-1:0]        raw_ff, raw_in;
   logic [LW-1:0]        dyn_ff, dyn_in;
   logic signed [17:0]   rate_ff, rate_in;
   logic                 allowed_ff, allowed_in;
   logic                 running_ff, running_in;
   logic signed [SPW-1:0] spd_ff, spd_in;
   logic [NW-1:0]        power_ff, power_in;
   logic signed [TW-1:0] prev_ff, prev_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0] rsp_torque_ff, rsp_torque_in;
   logic [LW-1:0]        rsp_lpos_ff, rsp_lpos_in;
   logic [LW-1:0]        rsp_dyn_ff, rsp_dyn_in;

   // combinational helpers
   logic                 req_fire;
   logic [ttcs_pkg::PEDAL_W-1:0] pedal_eff;
   logic [MW:0]          mul_sum;
   logic [DW:0]          div_trial;
   logic [DW:0]          div_diff;
   logic                 div_ge;
   logic [LW-1:0]        quo_next;
   logic                 ovf_next;
   logic [LW-1:0]        pass_cap;
   logic [LW-1:0]        pass_val;
   logic [DW-1:0]        spd_abs;
   logic [DW-1:0]        spd_div;
   logic signed [17:0]   rate_hi, rate_lo, raw_ext;
   logic signed [18:0]   neg_val;
   logic signed [18:0]   clamp_pos;
   logic signed [18:0]   clamp_neg;
   logic signed [TW-1:0] shaped;
   logic signed [TW:0]   spd_ext, max_ext;
   logic                 overspeed, standstill;
   logic signed [TW-1:0] torque_fin;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.torque_command = rsp_torque_ff;
   assign rsp_chan.pos_limit_out  = rsp_lpos_ff;
   assign rsp_chan.neg_limit_out  = '0;
   assign rsp_chan.dynamic_limit  = rsp_dyn_ff;

   assign pedal_eff = (req_chan.pedal < ttcs_pkg::PEDAL_DEAD) ? '0 : req_chan.pedal;

   // serial multiply / divide datapath
   assign mul_sum   = {1'b0, prod_ff[PW-1:NW]} + {1'b0, mcand_ff};
   assign div_trial = {rem_ff, prod_ff[PW-1]};
   assign div_diff  = div_trial - {1'b0, divr_ff};
   assign div_ge    = (div_trial >= {1'b0, divr_ff});
   assign quo_next  = {quo_ff[LW-2:0], div_ge};
   assign ovf_next  = ovf_ff | quo_ff[LW-1];
   assign pass_cap  = pass_ff ? torque_cap_ff : ttcs_pkg::RAW_SAT;
   assign pass_val  = (ovf_next || (quo_next > pass_cap)) ? pass_cap : quo_next;

   assign spd_abs = spd_ff[SPW-1] ? DW'(-spd_ff) : DW'(spd_ff);
   assign spd_div = (spd_abs < ttcs_pkg::SPEED_FLOOR) ? ttcs_pkg::SPEED_FLOOR : spd_abs;

   // rate limit
   assign raw_ext = {3'b000, raw_ff};
   assign rate_hi = {{2{prev_ff[TW-1]}}, prev_ff} + {3'b000, rate_step_ff};
   assign rate_lo = {{2{prev_ff[TW-1]}}, prev_ff} - {3'b000, rate_step_ff};

   // sign, clamps and speed checks
   assign neg_val   = mode_ff[0] ? -{rate_ff[17], rate_ff} : {rate_ff[17], rate_ff};
   assign clamp_pos = (neg_val > $signed({4'b0000, limit_pos_ff}))
                      ? $signed({4'b0000, limit_pos_ff}) : neg_val;
   assign clamp_neg = (clamp_pos < $signed({{3{limit_neg_ff[TW-1]}}, limit_neg_ff}))
                      ? $signed({{3{limit_neg_ff[TW-1]}}, limit_neg_ff}) : clamp_pos;
   assign shaped    = TW'(clamp_neg);
   assign spd_ext   = {spd_ff[SPW-1], spd_ff};
   assign max_ext   = {2'b00, max_speed_ff};
   assign overspeed = (spd_ext > max_ext) || (spd_ext < -max_ext);
   assign standstill = mode_ff[1] && (spd_ff > -16'sd10) && (spd_ff < 16'sd10)
                       && shaped[TW-1];
   assign torque_fin = (!allowed_ff || overspeed || standstill) ? '0 : shaped;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pass_in       = pass_ff;
      prod_in       = prod_ff;
      mcand_in      = mcand_ff;
      divr_in       = divr_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      ovf_in        = ovf_ff;
      raw_in        = raw_ff;
      dyn_in        = dyn_ff;
      rate_in       = rate_ff;
      allowed_in    = allowed_ff;
      running_in    = running_ff;
      spd_in        = spd_ff;
      power_in      = power_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_torque_in = rsp_torque_ff;
      rsp_lpos_in   = rsp_lpos_ff;
      rsp_dyn_in    = rsp_dyn_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               allowed_in = req_chan.allowed;
               running_in = (req_chan.inverter_state == ttcs_pkg::INV_RUNNING);
               spd_in     = req_chan.speed;
               power_in   = req_chan.power;
               unique case (req_chan.inverter_state)
                  ttcs_pkg::INV_OFF: begin
                  end
                  ttcs_pkg::INV_ERROR: begin
                     prev_in = '0;
                  end
                  ttcs_pkg::INV_READY, ttcs_pkg::INV_RUNNING: begin
                     if (req_chan.allowed) begin
                        pass_in  = 1'b0;
                        cnt_in   = '0;
                        prod_in  = PW'(pedal_eff);
                        mcand_in = {1'b0, setpoint_max_ff, 16'h0000};
                        divr_in  = ttcs_pkg::PERCENT_DIV;
                        state_in = ST_MUL;
                     end else begin
                        dyn_in   = '0;
                        state_in = ST_SHAPE;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in = prod_ff[0] ? {mul_sum, prod_ff[NW-1:1]}
                                 : {1'b0, prod_ff[PW-1:NW], prod_ff[NW-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ttcs_pkg::MUL_STEPS - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            prod_in = {prod_ff[PW-2:0], 1'b0};
            rem_in  = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
            quo_in  = quo_next;
            ovf_in  = ovf_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(ttcs_pkg::DIV_STEPS - 1)) begin
               cnt_in = '0;
               if (!pass_ff) begin
                  raw_in   = pass_val;
                  pass_in  = 1'b1;
                  prod_in  = PW'(power_ff);
                  mcand_in = power_gain_ff;
                  divr_in  = spd_div;
                  state_in = ST_MUL;
               end else begin
                  dyn_in   = pass_val;
                  state_in = ST_RATE;
               end
            end
         end
         ST_RATE: begin
            if (raw_ext > rate_hi) begin
               rate_in = rate_hi;
            end else if (raw_ext < rate_lo) begin
               rate_in = rate_lo;
            end else begin
               rate_in = raw_ext;
            end
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_torque_in = torque_fin;
               rsp_lpos_in   = ((torque_fin > 16'sd0) || (spd_ff != 16'sd0))
                               ? limit_pos_ff : '0;
               rsp_dyn_in    = dyn_ff;
               prev_in       = (allowed_ff && running_ff) ? torque_fin : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         pass_ff         <= 1'b0;
         prev_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         mode_ff         <= '0;
         setpoint_max_ff <= '0;
         rate_step_ff    <= '0;
         limit_pos_ff    <= '0;
         limit_neg_ff    <= '0;
         max_speed_ff    <= '0;
         power_gain_ff   <= '0;
         torque_cap_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               ttcs_pkg::REG_MODE:         mode_ff         <= csr_chan.data[1:0];
               ttcs_pkg::REG_SETPOINT_MAX: setpoint_max_ff <= csr_chan.data[LW-1:0];
               ttcs_pkg::REG_RATE_STEP:    rate_step_ff    <= csr_chan.data[LW-1:0];
               ttcs_pkg::REG_LIMIT_POS:    limit_pos_ff    <= csr_chan.data[LW-1:0];
               ttcs_pkg::REG_LIMIT_NEG:    limit_neg_ff    <= csr_chan.data[TW-1:0];
               ttcs_pkg::REG_MAX_SPEED:    max_speed_ff    <= csr_chan.data[LW-1:0];
               ttcs_pkg::REG_POWER_GAIN:   power_gain_ff   <= csr_chan.data[MW-1:0];
               ttcs_pkg::REG_TORQUE_CAP:   torque_cap_ff   <= csr_chan.data[LW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      divr_ff       <= divr_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      ovf_ff        <= ovf_in;
      raw_ff        <= raw_in;
      dyn_ff        <= dyn_in;
      rate_ff       <= rate_in;
      allowed_ff    <= allowed_in;
      running_ff    <= running_in;
      spd_ff        <= spd_in;
      power_ff      <= power_in;
      rsp_torque_ff <= rsp_torque_in;
      rsp_lpos_ff   <= rsp_lpos_in;
      rsp_dyn_ff    <= rsp_dyn_in;
   end

endmodule
